@@ rtl/core/mfs_pkg.sv @@
// shared constants, types and helpers for the message queue with search
package mfs_pkg;

	// ring storage
	localparam int unsigned DEPTH = 16;
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned OCC_W = $clog2(DEPTH + 1);

	// field widths
	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned SRC_W    = 16;
	localparam int unsigned MESG_W   = 32;
	localparam int unsigned CNT_W    = 32;
	localparam int unsigned ENTRY_W  = SRC_W + MESG_W;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_ENQ  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_DEQ  = 2'd1;
	localparam logic [FUNC_W-1:0] FN_SRCH = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd2;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_DEQ,
		S_SRCH,
		S_EMIT
	} state_t;

	// memory port controls
	typedef struct packed {
		logic             rd_en;
		logic [PTR_W-1:0] rd_addr;
		logic             wr_en;
		logic [PTR_W-1:0] wr_addr;
	} ram_ctl_t;

	// ring successor of a slot
	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
		logic [PTR_W-1:0] res;
		if (slot == PTR_W'(DEPTH - 1)) begin
			res = '0;
		end else begin
			res = slot + PTR_W'(1);
		end
		return res;
	endfunction

endpackage

@@ rtl/core/mfs_ram.sv @@
// single-port-write, single-port-read synchronous ram with registered read data
module mfs_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/core/mfs_ctrl.sv @@
// queue sequencer: ring pointers, counters, search scan and result register
module mfs_ctrl
	import mfs_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [FUNC_W-1:0]          func,
	input  logic [SRC_W-1:0]           src,
	input  logic [MESG_W-1:0]          mesg,
	output ram_ctl_t                   ram_ctl,
	output logic [ENTRY_W-1:0]         ram_wdata,
	input  logic [ENTRY_W-1:0]         ram_rdata,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_W-1:0]        status,
	output logic [SRC_W-1:0]           src_out,
	output logic [MESG_W-1:0]          mesg_out,
	output logic [CNT_W-1:0]           enq_total,
	output logic [CNT_W-1:0]           deq_total,
	output logic [PTR_W-1:0]           head_dbg,
	output logic [PTR_W-1:0]           tail_dbg,
	output logic [OCC_W-1:0]           occ_dbg,
	output state_t                     state_dbg,
	output logic [OCC_W-1:0]           scan_left_dbg
);

	state_t state_q, state_d;

	logic [PTR_W-1:0] head_q, tail_q, scan_ptr_q;
	logic [OCC_W-1:0] occ_q, scan_left_q;
	logic [CNT_W-1:0] enq_q, deq_q;
	logic             out_valid_q;

	logic [MESG_W-1:0]   key_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [SRC_W-1:0]    res_src_q;
	logic [MESG_W-1:0]   res_mesg_q;

	logic [STATUS_W-1:0] status_q;
	logic [SRC_W-1:0]    src_out_q;
	logic [MESG_W-1:0]   mesg_out_q;
	logic [CNT_W-1:0]    enq_total_q, deq_total_q;

	logic              accept, full, empty, hit, last, emit;
	logic [SRC_W-1:0]  rd_src;
	logic [MESG_W-1:0] rd_mesg;

	assign rd_src  = ram_rdata[ENTRY_W-1 -: SRC_W];
	assign rd_mesg = ram_rdata[MESG_W-1:0];
	assign full    = (occ_q == OCC_W'(DEPTH));
	assign empty   = (occ_q == '0);
	assign accept  = in_valid && in_ready;
	assign hit     = (rd_mesg == key_q);
	assign last    = (scan_left_q == OCC_W'(1));
	assign emit    = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (func)
						FN_DEQ:  state_d = empty ? S_EMIT : S_DEQ;
						FN_SRCH: state_d = empty ? S_EMIT : S_SRCH;
						default: state_d = S_EMIT;
					endcase
				end
			end
			S_DEQ: begin
				state_d = S_EMIT;
			end
			S_SRCH: begin
				if (hit || last) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready        = 1'b0;
		ram_ctl.rd_en   = 1'b0;
		ram_ctl.rd_addr = head_q;
		ram_ctl.wr_en   = 1'b0;
		ram_ctl.wr_addr = tail_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready      = 1'b1;
				ram_ctl.wr_en = in_valid && (func == FN_ENQ) && !full;
				ram_ctl.rd_en = in_valid && ((func == FN_DEQ) || (func == FN_SRCH)) && !empty;
			end
			S_SRCH: begin
				ram_ctl.rd_addr = scan_ptr_q;
				ram_ctl.rd_en   = !hit && !last;
			end
			default: begin
			end
		endcase
	end

	assign ram_wdata = {src, mesg};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			enq_q       <= '0;
			deq_q       <= '0;
			scan_ptr_q  <= '0;
			scan_left_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				case (func)
					FN_ENQ: begin
						if (!full) begin
							tail_q <= next_slot(tail_q);
							occ_q  <= occ_q + OCC_W'(1);
							enq_q  <= enq_q + CNT_W'(1);
						end
					end
					FN_DEQ: begin
						if (!empty) begin
							head_q <= next_slot(head_q);
							occ_q  <= occ_q - OCC_W'(1);
							deq_q  <= deq_q + CNT_W'(1);
						end
					end
					FN_SRCH: begin
						scan_ptr_q  <= next_slot(head_q);
						scan_left_q <= occ_q;
					end
					default: begin
					end
				endcase
			end
			if ((state_q == S_SRCH) && ram_ctl.rd_en) begin
				scan_ptr_q  <= next_slot(scan_ptr_q);
				scan_left_q <= scan_left_q - OCC_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result assembly and output register
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q      <= mesg;
			res_src_q  <= '0;
			res_mesg_q <= '0;
			case (func)
				FN_ENQ:  res_status_q <= full ? STAT_FULL : STAT_OK;
				FN_DEQ:  res_status_q <= empty ? STAT_MISS : STAT_OK;
				FN_SRCH: res_status_q <= STAT_MISS;
				default: res_status_q <= STAT_OK;
			endcase
		end
		if (state_q == S_DEQ) begin
			res_src_q  <= rd_src;
			res_mesg_q <= rd_mesg;
		end
		if ((state_q == S_SRCH) && hit) begin
			res_status_q <= STAT_OK;
			res_src_q    <= rd_src;
		end
		if (emit) begin
			status_q    <= res_status_q;
			src_out_q   <= res_src_q;
			mesg_out_q  <= res_mesg_q;
			enq_total_q <= enq_q;
			deq_total_q <= deq_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign src_out       = src_out_q;
	assign mesg_out      = mesg_out_q;
	assign enq_total     = enq_total_q;
	assign deq_total     = deq_total_q;
	assign head_dbg      = head_q;
	assign tail_dbg      = tail_q;
	assign occ_dbg       = occ_q;
	assign state_dbg     = state_q;
	assign scan_left_dbg = scan_left_q;

endmodule

@@ rtl/core/message_fifo_with_search.sv @@
// top level of the message queue with associative search
// A queue of up to DEPTH (source, message) pairs held in one synchronous ram in arrival order.
// Each transfer in carries one operation: enqueue appends a pair (or reports full and drops it),
// dequeue returns the oldest pair (or reports empty), search returns the source of the oldest
// entry whose message equals the key (or reports not found) without removing anything. Every
// result also carries the running counts of accepted enqueues and successful dequeues, wrapping
// at 32 bits. One operation is worked on at a time: the result is loaded into the output
// register from the result state, which an enqueue, a miss on an empty queue or an unused
// code reaches straight after the input transfer, a dequeue after its read state, and a search
// after scanning up to the entry that ends it (at most the occupancy, so up to DEPTH entries).
// The next transfer in is taken once the result is loaded, and the scan reads the ram one
// entry per cycle through its single read port. A new transfer in is taken while a finished
// result still waits in the output register; only the next result waits for it to drain.
// The ram needs no clearing after reset, because only occupied entries are ever read.
module message_fifo_with_search
	import mfs_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [FUNC_W-1:0]          func,
	input  logic [SRC_W-1:0]           src,
	input  logic signed [MESG_W-1:0]   mesg,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [STATUS_W-1:0]        status,
	output logic [SRC_W-1:0]           src_out,
	output logic signed [MESG_W-1:0]   mesg_out,
	output logic [CNT_W-1:0]           enq_total,
	output logic [CNT_W-1:0]           deq_total
);

	// memory port controls and data
	ram_ctl_t           ram_ctl;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [MESG_W-1:0]  mesg_out_raw;

	// sequencer state seen by the checks below
	logic [PTR_W-1:0] head_dbg, tail_dbg;
	logic [OCC_W-1:0] occ_dbg, scan_left_dbg;
	state_t           state_dbg;

	// sequencer: pointers, counters, search scan, result register
	mfs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.func          (func),
		.src           (src),
		.mesg          (MESG_W'(unsigned'(mesg))),
		.ram_ctl       (ram_ctl),
		.ram_wdata     (ram_wdata),
		.ram_rdata     (ram_rdata),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.src_out       (src_out),
		.mesg_out      (mesg_out_raw),
		.enq_total     (enq_total),
		.deq_total     (deq_total),
		.head_dbg      (head_dbg),
		.tail_dbg      (tail_dbg),
		.occ_dbg       (occ_dbg),
		.state_dbg     (state_dbg),
		.scan_left_dbg (scan_left_dbg)
	);

	assign mesg_out = signed'(mesg_out_raw);

	// ring storage: source in the upper bits, message in the lower bits
	// a write and a read of the same entry never share a cycle, the sequencer
	// always passes through the result state between two operations
	mfs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_ctl.wr_en),
		.wr_addr (ram_ctl.wr_addr),
		.wr_data (ram_wdata),
		.rd_en   (ram_ctl.rd_en),
		.rd_addr (ram_ctl.rd_addr),
		.rd_data (ram_rdata)
	);

	// occupancy never goes beyond the ring size
	assert property (@(posedge clk) disable iff (!arst_n)
		occ_dbg <= OCC_W'(DEPTH))
		else $error("occupancy beyond ring size");

	// tail always sits occupancy slots after head
	assert property (@(posedge clk) disable iff (!arst_n)
		tail_dbg == PTR_W'((int'(head_dbg) + int'(occ_dbg)) % DEPTH))
		else $error("ring pointers out of step with occupancy");

	// an enqueue onto a full ring leaves the tail alone
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (func == FN_ENQ) && (occ_dbg == OCC_W'(DEPTH)))
		|=> $stable(tail_dbg) && $stable(occ_dbg))
		else $error("dropped enqueue changed the ring");

	// the scan never runs past the occupied entries
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_dbg == S_SRCH) |-> (scan_left_dbg != '0) && (scan_left_dbg <= occ_dbg))
		else $error("search scan outside occupied entries");

	// no write lands in the ring while an operation is still in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_ctl.wr_en |-> (state_dbg == S_IDLE) && !ram_ctl.rd_en)
		else $error("ring written outside idle");

endmodule
